>>> rtl/itrd_pkg.sv
// Shared constants, types and helper functions for the radix digit converter.
package itrd_pkg;

	localparam int VALUE_BITS  = 31;
	localparam int DIGIT_SLOTS = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int RADIX_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int SLOT_W    = $clog2(DIGIT_SLOTS);
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 8'h41;

	// One work item handed from the front end to the converter
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  is_zero;
	} itrd_item_t;

	// Clamp the programmed radix into the supported range
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	// Map a digit value to its ASCII character, uppercase letters above nine
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DIGIT_NINE)
			res = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
		else
			res = CHAR_ZERO + CHAR_W'(d);
		return res;
	endfunction

endpackage

>>> rtl/itrd_front.sv
// Input front end: takes values, flags zero and hands them to the work queue.
module itrd_front import itrd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  push,
	output itrd_item_t            push_item,
	input  logic                  q_full
);

	logic       hold_valid_q;
	itrd_item_t hold_item_q;
	logic       accept;

	// Stall only while the held item cannot move on
	assign push      = hold_valid_q && !q_full;
	assign in_stall  = hold_valid_q && q_full;
	assign accept    = in_valid && !in_stall;
	assign push_item = hold_item_q;

	// Track the holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	// Capture and classify the transferred value
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_item_q.value   <= value;
			hold_item_q.is_zero <= (value == '0);
		end
	end

endmodule

>>> rtl/itrd_queue.sv
// Short work queue between the front end and the converter.
module itrd_queue import itrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  itrd_item_t push_item,
	output logic       full,
	input  logic       pop,
	output itrd_item_t pop_item,
	output logic       empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	itrd_item_t       slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_item;
	end

	// Occupancy stays within the queue depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy out of range");

	// Occupancy moves by one step only
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue push not counted");

	// The front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

>>> rtl/itrd_back.sv
// Converter back end: bit-serial division by the radix, digit buffer and emission.
module itrd_back import itrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RADIX_W-1:0] radix,
	input  logic               q_empty,
	input  itrd_item_t         q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [SLOT_W-1:0]     idx_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     digit_char_q;
	logic                  last_q;
	logic [RADIX_W-1:0]    rd_digit_q;
	logic [RADIX_W-1:0]    digit_mem [DIGIT_SLOTS];

	logic [RADIX_W-1:0]    eff;
	logic [RADIX_W:0]      trial;
	logic [RADIX_W:0]      diff;
	logic                  ge;
	logic [RADIX_W-1:0]    rem_next;
	logic [VALUE_BITS-1:0] quo_next;
	logic                  bit_last;
	logic                  out_free;
	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_waddr;
	logic [RADIX_W-1:0]    mem_wdata;

	// One restoring-division step per cycle
	assign eff      = eff_radix(radix);
	assign trial    = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff     = trial - {1'b0, eff};
	assign ge       = (trial >= {1'b0, eff});
	assign rem_next = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
	assign quo_next = {quo_q[VALUE_BITS-2:0], ge};
	assign bit_last = (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1));

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	// Write a remainder at the end of each division, or a single zero digit
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rem_next;
		case (state_q)
			S_IDLE: begin
				if (!q_empty && q_item.is_zero) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = '0;
				end
			end
			S_DIV: begin
				mem_we = bit_last;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Digit buffer with registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			digit_mem[mem_waddr] <= mem_wdata;
		if (state_q == S_EMIT_RD)
			rd_digit_q <= digit_mem[idx_q];
	end

	// Sequence division and emission, hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			quo_q        <= '0;
			rem_q        <= '0;
			bit_cnt_q    <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			digit_char_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT_LD)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						quo_q     <= q_item.value;
						rem_q     <= '0;
						bit_cnt_q <= '0;
						idx_q     <= '0;
						state_q   <= q_item.is_zero ? S_EMIT_RD : S_DIV;
					end
				end
				S_DIV: begin
					quo_q <= quo_next;
					if (bit_last) begin
						rem_q     <= '0;
						bit_cnt_q <= '0;
						if (quo_next == '0 || idx_q == SLOT_W'(DIGIT_SLOTS - 1))
							state_q <= S_EMIT_RD;
						else
							idx_q <= idx_q + 1'b1;
					end else begin
						rem_q     <= rem_next;
						bit_cnt_q <= bit_cnt_q + 1'b1;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						digit_char_q <= digit_to_ascii(rd_digit_q);
						last_q       <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	// Partial remainder always stays below the radix
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < eff))
		else $error("partial remainder not below radix");

	// Bit counter never runs past the value width
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1)))
		else $error("division bit counter overrun");

	// A pending output digit is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(digit_char_q)))
		else $error("pending digit overwritten");

	// A new item is taken only after the last digit has been loaded
	a_pop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && out_valid_q) |-> last_q)
		else $error("new item taken before digits finished");

endmodule

>>> rtl/integer_to_radix_digits_core.sv
// Top level of the integer to radix digit converter.
//
// Input channel: value with in_valid / in_stall; a transfer happens on a
// clock edge with in_valid high and in_stall low. A front register and a
// two-entry queue take up to three values ahead of the converter.
// Output channel: digit_char and last with out_valid / out_stall, one
// transfer per digit, most significant first; last marks the final digit.
// Configuration: cfg_we writes cfg_wdata into the radix register; write it
// only while the block is idle. Radix 0 or 1 acts as 2, above 36 as 36.
// The value passes the front register and the queue to the converter, which
// runs a full division by the radix for each digit (one quotient bit per cycle
// through the shared restoring divider), then reads each digit from the digit
// buffer and loads it into the output register. A zero value skips the division.
// While out_stall is high the current digit holds and the converter waits;
// the front end keeps taking values until the queue fills.
// Reset (arst_n low) empties queue and output and sets the radix to 10.
module integer_to_radix_digits_core import itrd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [RADIX_W-1:0]    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last
);

	logic [RADIX_W-1:0] radix_q;
	logic               push;
	itrd_item_t         push_item;
	logic               q_full;
	logic               pop;
	itrd_item_t         q_item;
	logic               q_empty;

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	itrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	itrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (q_item),
		.empty     (q_empty)
	);

	itrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

>>> tb/integer_to_radix_digits_core_test.sv
// Self-checking testbench for the integer to radix digit converter core.
`timescale 1ns / 1ps

module integer_to_radix_digits_core_test;
	import itrd_pkg::*;

	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASES       = 12;
	localparam int PHASE_VALUES = 38;
	localparam int SETTLE       = 40;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} digit_exp_t;

	// Expected digit stream, rebuilt from each accepted value and the programmed radix
	class digit_tracker;
		logic [RADIX_W-1:0] radix;
		digit_exp_t         due_digits[$];
		int                 errors;

		function new();
			radix  = RADIX_RESET;
			errors = 0;
		endfunction

		function void set_radix(logic [RADIX_W-1:0] r);
			radix = r;
		endfunction

		function int pending();
			return due_digits.size();
		endfunction

		// Divide repeatedly, then queue the digits most significant first
		function void add_value(logic [VALUE_BITS-1:0] v);
			string              glyphs;
			logic [RADIX_W-1:0] base;
			logic [VALUE_BITS-1:0] rest;
			logic [RADIX_W-1:0] rems[$];
			digit_exp_t         d;
			int                 k;
			glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
			base = radix;
			if (base < RADIX_MIN)
				base = RADIX_MIN;
			else if (base > RADIX_MAX)
				base = RADIX_MAX;
			rest = v;
			do begin
				rems = {rems, RADIX_W'(rest % base)};
				rest = rest / base;
			end while (rest != 0 && rems.size() < DIGIT_SLOTS);
			for (k = rems.size() - 1; k >= 0; k--) begin
				d.ch  = glyphs[rems[k]];
				d.fin = (k == 0);
				due_digits = {due_digits, d};
			end
		endfunction

		function void check_digit(logic [CHAR_W-1:0] ch, logic fin);
			digit_exp_t d;
			if (due_digits.size() == 0) begin
				$display("%0t: unexpected digit: expected none, actual char %h last %b",
					$time, ch, fin);
				errors++;
				return;
			end
			d = due_digits.pop_front();
			if (ch !== d.ch) begin
				$display("%0t: digit_char mismatch: expected %h, actual %h", $time, d.ch, ch);
				errors++;
			end
			if (fin !== d.fin) begin
				$display("%0t: last mismatch: expected %b, actual %b", $time, d.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [RADIX_W-1:0]    cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CHAR_W-1:0]     digit_char;
	logic                  last;

	digit_tracker board;
	logic         no_idle = 1'b0;
	int           quiet_cycles = 0;

	integer_to_radix_digits_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Values of random width up to the full width, now and then zero
	function automatic logic [VALUE_BITS-1:0] rand_value();
		logic [VALUE_BITS-1:0] v;
		int                    w;
		w = $urandom_range(1, VALUE_BITS);
		v = VALUE_BITS'($urandom);
		v = v >> (VALUE_BITS - w);
		if ($urandom_range(0, 15) == 0)
			v = '0;
		return v;
	endfunction

	// Watch every transfer and track quiet stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.set_radix(cfg_wdata);
			if (in_valid && !in_stall)
				board.add_value(value);
			if (out_valid && !out_stall)
				board.check_digit(digit_char, last);
			if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Hold the output side off for a random number of cycles before each digit
	initial begin : digit_sink
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_gap();
			if (hold != 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Present one value after a random gap and hold it until the transfer
	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = draw_gap();
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop the input and wait for every queued digit to come out
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int                 phase;
		int                 n;
		logic [RADIX_W-1:0] r;
		board = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset radix: zero, single digit, carry into a second digit, largest value
		send_value(31'd0);
		send_value(31'd1);
		send_value(31'd9);
		send_value(31'd10);
		send_value(31'd1000000000);
		send_value(31'h7FFF_FFFF);

		// Base two: longest digit strings
		write_radix(6'd2);
		send_value(31'd0);
		send_value(31'd1);
		send_value(31'h7FFF_FFFF);
		send_value(31'h4000_0000);
		send_value(31'h5555_5555);

		// Base thirty-six: full letter range
		write_radix(6'd36);
		send_value(31'd35);
		send_value(31'd36);
		send_value(31'd1295);
		send_value(31'h7FFF_FFFF);

		// Radix below range acts as two, above range as thirty-six
		write_radix(6'd0);
		send_value(31'd5);
		write_radix(6'd1);
		send_value(31'd6);
		write_radix(6'd37);
		send_value(31'd71);
		write_radix(6'd63);
		send_value(31'h7FFF_FFFF);

		write_radix(6'd16);
		send_value(31'h7FFF_FFFF);
		send_value(31'h00AB_CDEF);

		// Random phases, each with its own radix and idle pattern
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				r = 6'd2;
			else if (phase == 1)
				r = 6'd36;
			else if ($urandom_range(0, 4) == 0)
				r = RADIX_W'($urandom_range(0, 63));
			else
				r = RADIX_W'($urandom_range(2, 36));
			write_radix(r);
			no_idle = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_VALUES; n++)
				send_value(rand_value());
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
rtl/itrd_pkg.sv
rtl/itrd_front.sv
rtl/itrd_queue.sv
rtl/itrd_back.sv
rtl/integer_to_radix_digits_core.sv
tb/integer_to_radix_digits_core_test.sv
